// ===== rtl/sed_pkg.sv =====
// sed_pkg: beat types and character constants for the string escape decoder
// no dependencies; imported by every module of the block
`default_nettype none

package sed_pkg;

  localparam logic [7:0] BACKSLASH  = 8'h5C;
  localparam logic [7:0] ERROR_CHAR = 8'h3F;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } in_t;

  typedef struct packed {
    logic       has_char;
    logic [7:0] out_char;
    logic       bad_escape;
    logic       end_of_string;
  } res_t;

  // up to two result beats caused by one input beat
  typedef struct packed {
    logic two;
    res_t first;
    res_t second;
  } op_t;

endpackage

`default_nettype wire

// ===== rtl/string_escape_decoder_unit.sv =====
// string_escape_decoder_unit: top level of the escape decoder
// depends on sed_pkg, sed_front, sed_queue, sed_back
//
//   channel  | ports                  | beat
//   input    | push, full, item       | one string character and its last mark
//   result   | empty, pop, result     | one decoded character with flags
//
// one character accepted per cycle while the op queue has room
// each character gives zero, one or two result beats; the back end
// delivers one result beat per cycle while result beats are popped
// an accepted character's op goes through the queue, then the output register
// rst clears the escape mode, the queue and the output valid flags
`default_nettype none

module string_escape_decoder_unit #(
  parameter int DEPTH = 2
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  output logic              full,
  input  wire sed_pkg::in_t item,
  output logic              empty,
  input  wire logic         pop,
  output sed_pkg::res_t     result
);
  import sed_pkg::*;

  logic op_push, q_full, q_valid, q_rd;
  op_t  op_w, op_r;

  sed_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .item    (item),
    .q_full  (q_full),
    .op_push (op_push),
    .op      (op_w)
  );

  sed_queue #(.DEPTH(DEPTH)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (op_push),
    .wr_op   (op_w),
    .q_full  (q_full),
    .q_valid (q_valid),
    .rd      (q_rd),
    .rd_op   (op_r)
  );

  sed_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_op    (op_r),
    .q_rd    (q_rd),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule

`default_nettype wire

// ===== rtl/sed_front.sv =====
// sed_front: accepts character beats, tracks escape mode, builds result ops
// depends on sed_pkg
`default_nettype none

module sed_front (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  output logic              full,
  input  wire sed_pkg::in_t item,
  input  wire logic         q_full,
  output logic              op_push,
  output sed_pkg::op_t      op
);
  import sed_pkg::*;

  typedef enum logic [3:0] {
    MODE_TEXT  = 4'b0001,
    MODE_ESC   = 4'b0010,
    MODE_HEX_A = 4'b0100,
    MODE_HEX_B = 4'b1000
  } mode_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c >= "0" && c <= "9") v = c - "0";
    else if (c >= "a" && c <= "f") v = c - "a" + 8'd10;
    else if (c >= "A" && c <= "F") v = c - "A" + 8'd10;
    return v[3:0];
  endfunction

  mode_t      mode, mode_next;
  logic [7:0] held_digit, held_digit_next;

  logic       accept;
  logic [7:0] c, lc;
  logic       fin;
  logic       t_emit;
  res_t       t_res;
  mode_t      t_mode;
  logic       emit0, emit1;
  res_t       r0, r1;

  assign full   = q_full;
  assign accept = push && !q_full;
  assign c      = item.ch;
  assign fin    = item.last;
  assign lc     = (c >= "A" && c <= "Z") ? c + 8'd32 : c;

  // plain text handling of the current character
  always_comb begin
    t_emit = (c != BACKSLASH) || fin;
    t_res.has_char      = 1'b1;
    t_res.out_char      = (c == BACKSLASH) ? ERROR_CHAR : c;
    t_res.bad_escape    = (c == BACKSLASH);
    t_res.end_of_string = 1'b0;
    t_mode = (c == BACKSLASH && !fin) ? MODE_ESC : MODE_TEXT;
  end

  always_comb begin
    emit0           = 1'b0;
    emit1           = 1'b0;
    r0              = '0;
    r1              = '0;
    mode_next       = mode;
    held_digit_next = held_digit;
    unique case (mode)
      MODE_TEXT: begin
        emit0     = t_emit;
        r0        = t_res;
        mode_next = t_mode;
      end
      MODE_ESC: begin
        mode_next   = MODE_TEXT;
        emit0       = 1'b1;
        r0.has_char = 1'b1;
        unique case (lc)
          "a":     r0.out_char = 8'd7;
          "b":     r0.out_char = 8'd8;
          "f":     r0.out_char = 8'd12;
          "v":     r0.out_char = 8'd11;
          "r":     r0.out_char = 8'd13;
          "n":     r0.out_char = 8'd10;
          "t":     r0.out_char = 8'd9;
          8'h27, 8'h22, BACKSLASH: r0.out_char = c;
          "x": begin
            if (fin) begin
              r0.has_char   = 1'b0;
              r0.bad_escape = 1'b1;
            end else begin
              emit0     = 1'b0;
              mode_next = MODE_HEX_A;
            end
          end
          default: begin
            r0.out_char   = ERROR_CHAR;
            r0.bad_escape = 1'b1;
          end
        endcase
      end
      MODE_HEX_A: begin
        if (is_hex(c) && !fin) begin
          held_digit_next = c;
          mode_next       = MODE_HEX_B;
        end else begin
          emit0     = t_emit;
          r0        = t_res;
          mode_next = t_mode;
        end
      end
      MODE_HEX_B: begin
        emit0       = 1'b1;
        r0.has_char = 1'b1;
        if (is_hex(c)) begin
          r0.out_char = {hex_val(held_digit), hex_val(c)};
          mode_next   = MODE_HEX_A;
        end else begin
          r0.out_char = held_digit;
          emit1       = t_emit;
          r1          = t_res;
          mode_next   = t_mode;
        end
      end
      default: mode_next = MODE_TEXT;
    endcase
    if (fin) begin
      mode_next = MODE_TEXT;
    end
  end

  always_comb begin
    op.two    = emit1;
    op.first  = r0;
    op.second = r1;
    op.first.end_of_string  = fin && !emit1;
    op.second.end_of_string = fin && emit1;
  end

  assign op_push = accept && emit0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_TEXT;
      held_digit <= 8'd0;
    end else if (accept) begin
      mode       <= mode_next;
      held_digit <= held_digit_next;
    end
  end

  a_emit1_needs_emit0: assert property (@(posedge clk) disable iff (rst)
    emit1 |-> emit0) else $error("second result without a first");
  a_fin_resets_mode: assert property (@(posedge clk) disable iff (rst)
    (accept && fin) |=> mode == MODE_TEXT) else $error("mode not cleared at end of string");

endmodule

`default_nettype wire

// ===== rtl/sed_queue.sv =====
// sed_queue: short queue of result ops between front and back
// depends on sed_pkg
`default_nettype none

module sed_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         wr,
  input  wire sed_pkg::op_t wr_op,
  output logic              q_full,
  output logic              q_valid,
  input  wire logic         rd,
  output sed_pkg::op_t      rd_op
);
  import sed_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  op_t           slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr, do_rd;

  assign q_full  = (count == CW'(DEPTH));
  assign q_valid = (count != '0);
  assign do_wr   = wr && !q_full;
  assign do_rd   = rd && q_valid;
  assign rd_op   = slots[rd_ptr];

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= bump(wr_ptr);
      if (do_rd) rd_ptr <= bump(rd_ptr);
      if (do_wr && !do_rd) count <= count + 1'b1;
      else if (do_rd && !do_wr) count <= count - 1'b1;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH)) else $error("queue count beyond depth");
  a_fill_to_full: assert property (@(posedge clk) disable iff (rst)
    (do_wr && !do_rd && count == CW'(DEPTH - 1)) |=> q_full)
    else $error("queue not full after last slot filled");

endmodule

`default_nettype wire

// ===== rtl/sed_back.sv =====
// sed_back: unpacks ops into single result beats behind an output register
// depends on sed_pkg
`default_nettype none

module sed_back (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         q_valid,
  input  wire sed_pkg::op_t q_op,
  output logic              q_rd,
  output logic              empty,
  input  wire logic         pop,
  output sed_pkg::res_t     result
);
  import sed_pkg::*;

  logic out_valid, pend_valid;
  res_t out_res, pend_res;
  logic slot_free;

  assign slot_free = !out_valid || pop;
  assign q_rd      = slot_free && !pend_valid && q_valid;
  assign empty     = !out_valid;
  assign result    = out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (slot_free) begin
      if (pend_valid) begin
        out_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end else begin
        out_valid  <= q_valid;
        pend_valid <= q_valid && q_op.two;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free) begin
      if (pend_valid) begin
        out_res <= pend_res;
      end else if (q_valid) begin
        out_res  <= q_op.first;
        pend_res <= q_op.second;
      end
    end
  end

  a_pend_behind_out: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> out_valid) else $error("held second beat without a first");
  a_pend_follows: assert property (@(posedge clk) disable iff (rst)
    (out_valid && pop && pend_valid) |=> (out_valid && !pend_valid))
    else $error("held second beat not moved out");

endmodule

`default_nettype wire
